>>> design/usmc_pkg.sv
// Shared types, constants and the coordinate rounding function of the UV-sphere cell unit.
package usmc_pkg;

  localparam logic [8:0] MAX_RINGS = 9'd256;
  localparam logic [8:0] MAX_SEGMENTS = 9'd256;
  localparam logic [8:0] MIN_SEGMENTS = 9'd3;
  localparam logic [8:0] RING_COUNT_RST = 9'd8;
  localparam logic [8:0] SEGMENT_COUNT_RST = 9'd16;
  localparam int COORD_FRAC_BITS = 14;

  localparam int DIV_LAT = 32;
  localparam int TRIG_LAT = 23;
  localparam int HORNER_STEPS = 6;

  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [31:0] HALF_PI_Q31 = 32'd3373259426;
  localparam logic [30:0] QUARTER = 31'h4000_0000;
  localparam logic [29:0] EIGHTH = 30'h2000_0000;

  localparam logic [7:0] SIN_DEN [HORNER_STEPS] = '{8'd1, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [7:0] COS_DEN [HORNER_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
  localparam logic [30:0] SIN_RCP [HORNER_STEPS] = '{
    31'd0,
    31'((64'd1 << 31) / 64'd110),
    31'((64'd1 << 31) / 64'd72),
    31'((64'd1 << 31) / 64'd42),
    31'((64'd1 << 31) / 64'd20),
    31'((64'd1 << 31) / 64'd6)
  };
  localparam logic [30:0] COS_RCP [HORNER_STEPS] = '{
    31'((64'd1 << 31) / 64'd132),
    31'((64'd1 << 31) / 64'd90),
    31'((64'd1 << 31) / 64'd56),
    31'((64'd1 << 31) / 64'd30),
    31'((64'd1 << 31) / 64'd12),
    31'((64'd1 << 31) / 64'd2)
  };

  localparam int UNIT_COORD = 1 << COORD_FRAC_BITS;
  localparam logic [15:0] NORTH_Z = 16'(UNIT_COORD > 32767 ? 32767 : UNIT_COORD);
  localparam logic [15:0] SOUTH_Z = 16'(-(UNIT_COORD > 32768 ? 32768 : UNIT_COORD));

  typedef enum logic {
    REG_RING_COUNT = 1'b0,
    REG_SEGMENT_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_VERTEX = 2'd0,
    KIND_FACE = 2'd1,
    KIND_INVALID = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CELL_INVALID,
    CELL_NORTH,
    CELL_SOUTH,
    CELL_BODY
  } cell_class_t;

  typedef struct packed {
    cell_class_t cls;
    logic [8:0] ring;
    logic [7:0] seg;
    logic [7:0] segn;
  } cell_info_t;

  typedef struct packed {
    cell_class_t cls;
    logic has_vertex;
    logic [1:0] nfaces;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [16:0] vid;
    logic [16:0] a0;
    logic [16:0] b0;
    logic [16:0] c0;
    logic [16:0] a1;
    logic [16:0] b1;
    logic [16:0] c1;
  } cell_result_t;

  // Rounds v >> sh half away from zero and saturates to 16-bit signed.
  function automatic logic [15:0] to_coord(input logic signed [65:0] v, input int sh);
    logic [65:0] mag;
    logic [65:0] r;
    logic [15:0] res;
    mag = v[65] ? 66'(-v) : 66'(v);
    r = (mag + (66'd1 << (sh - 1))) >> sh;
    if (v[65]) begin
      res = (r > 66'd32768) ? 16'h8000 : 16'(66'd0 - r);
    end else begin
      res = (r > 66'd32767) ? 16'h7fff : r[15:0];
    end
    return res;
  endfunction

endpackage

>>> design/usmc_div.sv
// Pipelined restoring divider that turns a ring or segment index into a 32-bit phase.
module usmc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [10:0] num,
  input  logic [10:0] den,
  output logic [31:0] quo
);

  logic [10:0] rem [usmc_pkg::DIV_LAT];
  logic [31:0] qt [usmc_pkg::DIV_LAT];

  for (genvar i = 0; i < usmc_pkg::DIV_LAT; i++) begin : g_stage
    logic [10:0] rem_in;
    logic [31:0] q_in;
    logic [11:0] dbl;
    logic ge;

    always_comb begin
      rem_in = (i == 0) ? num : rem[(i == 0) ? 0 : i - 1];
      q_in = (i == 0) ? 32'd0 : qt[(i == 0) ? 0 : i - 1];
      dbl = {rem_in, 1'b0};
      ge = dbl >= {1'b0, den};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? 11'(dbl - {1'b0, den}) : dbl[10:0];
        qt[i] <= {q_in[30:0], ge};
      end
    end
  end

  assign quo = qt[usmc_pkg::DIV_LAT - 1];

endmodule

>>> design/usmc_trig.sv
// Pipelined fixed-point sine of a 32-bit phase using Horner-form Taylor series.
module usmc_trig (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [32:0] sine
);

  typedef struct packed {
    logic [30:0] x;
    logic [30:0] x2;
    logic [31:0] t;
    logic use_sin;
    logic neg;
  } arg_t;

  logic [30:0] g;
  logic g_sin;
  logic [29:0] u0;
  logic use0;
  logic neg0;
  logic [61:0] p1;
  logic [30:0] x1;
  logic use1;
  logic neg1;
  logic [61:0] p2;
  arg_t st [usmc_pkg::HORNER_STEPS + 1];
  logic [62:0] pf;
  logic [31:0] fmag;
  logic fneg;

  always_comb begin
    g = phase[30] ? (usmc_pkg::QUARTER - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    g_sin = g <= {1'b0, usmc_pkg::EIGHTH};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u0 <= g_sin ? g[29:0] : 30'(usmc_pkg::QUARTER - g);
      use0 <= g_sin;
      neg0 <= phase[31];
    end
  end

  assign p1 = 62'(u0) * 62'(usmc_pkg::HALF_PI_Q31);

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= p1[60:30];
      use1 <= use0;
      neg1 <= neg0;
    end
  end

  assign p2 = 62'(x1) * 62'(x1);

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].x <= x1;
      st[0].x2 <= p2[61:31];
      st[0].t <= usmc_pkg::ONE_Q31;
      st[0].use_sin <= use1;
      st[0].neg <= neg1;
    end
  end

  for (genvar k = 0; k < usmc_pkg::HORNER_STEPS; k++) begin : g_step
    arg_t sa;
    arg_t sb;
    arg_t nx;
    logic [30:0] na;
    logic [30:0] nb;
    logic [30:0] qb;
    logic [62:0] pa;
    logic [61:0] pb;
    logic [30:0] rcp;
    logic [7:0] dv;
    logic [38:0] qd;
    logic [31:0] rr;
    logic [30:0] q;

    assign pa = 63'(st[k].x2) * 63'(st[k].t);

    always_ff @(posedge clk) begin
      if (en) begin
        na <= pa[61:31];
        sa <= st[k];
      end
    end

    assign rcp = sa.use_sin ? usmc_pkg::SIN_RCP[k] : usmc_pkg::COS_RCP[k];
    assign pb = 62'(na) * 62'(rcp);

    always_ff @(posedge clk) begin
      if (en) begin
        qb <= pb[61:31];
        nb <= na;
        sb <= sa;
      end
    end

    always_comb begin
      dv = sb.use_sin ? usmc_pkg::SIN_DEN[k] : usmc_pkg::COS_DEN[k];
      qd = 39'(qb) * 39'(dv);
      rr = {1'b0, nb} - qd[31:0];
      q = (rr >= 32'(dv)) ? qb + 31'd1 : qb;
      nx = sb;
      if (!(sb.use_sin && k == 0)) begin
        nx.t = usmc_pkg::ONE_Q31 - 32'(q);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k + 1] <= nx;
      end
    end
  end

  assign pf = 63'(st[usmc_pkg::HORNER_STEPS].x) * 63'(st[usmc_pkg::HORNER_STEPS].t);

  always_ff @(posedge clk) begin
    if (en) begin
      fmag <= st[usmc_pkg::HORNER_STEPS].use_sin ? pf[62:31] : st[usmc_pkg::HORNER_STEPS].t;
      fneg <= st[usmc_pkg::HORNER_STEPS].neg;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= fneg ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
    end
  end

endmodule

>>> design/usmc_front.sv
// Front end: accepts cells, classifies them and computes vertex positions and mesh indices.
module usmc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [8:0]             ring_count,
  input  logic [8:0]             segment_count,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [23:0]            s_tdata,
  input  logic                   full,
  output logic                   push,
  output usmc_pkg::cell_result_t entry
);

  localparam int DL = usmc_pkg::DIV_LAT + usmc_pkg::TRIG_LAT + 1;

  logic adv;
  logic [8:0] in_ring;
  logic [7:0] in_seg;
  logic cfg_bad;
  logic [9:0] r1;
  logic [8:0] seg1;
  logic [7:0] segn;
  usmc_pkg::cell_info_t info_c;

  logic s0_vld;
  usmc_pkg::cell_info_t s0_info;
  logic [10:0] num_a;
  logic [10:0] num_b;
  logic [31:0] pa;
  logic [31:0] pb;
  logic signed [32:0] sa;
  logic signed [32:0] ca;
  logic signed [32:0] sb;
  logic signed [32:0] cb;

  logic [DL-1:0] dl_vld;
  usmc_pkg::cell_info_t dl_info [DL];
  logic signed [65:0] px;
  logic signed [65:0] py;
  logic signed [32:0] pz;

  usmc_pkg::cell_info_t fin;
  logic [17:0] lo;
  logic [17:0] hi;
  logic [17:0] j1;
  logic [17:0] jn1;
  logic [16:0] bl;
  logic [16:0] br;
  logic [16:0] tl;
  logic [16:0] tr;
  logic [16:0] pole;
  usmc_pkg::cell_result_t res_c;
  logic out_vld;

  assign adv = !(out_vld && full);
  assign s_tready = adv;
  assign push = out_vld && !full;

  assign in_ring = s_tdata[8:0];
  assign in_seg = s_tdata[16:9];

  always_comb begin
    cfg_bad = (ring_count == 9'd0) || (ring_count > usmc_pkg::MAX_RINGS) ||
              (segment_count < usmc_pkg::MIN_SEGMENTS) ||
              (segment_count > usmc_pkg::MAX_SEGMENTS);
    r1 = {1'b0, ring_count} + 10'd1;
    seg1 = {1'b0, in_seg} + 9'd1;
    segn = (seg1 == segment_count) ? 8'd0 : seg1[7:0];
    info_c.ring = in_ring;
    info_c.seg = in_seg;
    info_c.segn = segn;
    if (cfg_bad || ({1'b0, in_ring} > r1) || ({1'b0, in_seg} >= segment_count)) begin
      info_c.cls = usmc_pkg::CELL_INVALID;
    end else if (in_ring == 9'd0) begin
      info_c.cls = usmc_pkg::CELL_NORTH;
    end else if ({1'b0, in_ring} == r1) begin
      info_c.cls = usmc_pkg::CELL_SOUTH;
    end else begin
      info_c.cls = usmc_pkg::CELL_BODY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_info <= info_c;
      num_a <= 11'(in_ring);
      num_b <= 11'(segn);
    end
  end

  usmc_div u_div_a (
    .clk (clk),
    .en  (adv),
    .num (num_a),
    .den ({r1, 1'b0}),
    .quo (pa)
  );

  usmc_div u_div_b (
    .clk (clk),
    .en  (adv),
    .num (num_b),
    .den (11'(segment_count)),
    .quo (pb)
  );

  usmc_trig u_sin_a (
    .clk   (clk),
    .en    (adv),
    .phase (pa),
    .sine  (sa)
  );

  usmc_trig u_cos_a (
    .clk   (clk),
    .en    (adv),
    .phase (pa + 32'(usmc_pkg::QUARTER)),
    .sine  (ca)
  );

  usmc_trig u_sin_b (
    .clk   (clk),
    .en    (adv),
    .phase (pb),
    .sine  (sb)
  );

  usmc_trig u_cos_b (
    .clk   (clk),
    .en    (adv),
    .phase (pb + 32'(usmc_pkg::QUARTER)),
    .sine  (cb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dl_vld <= '0;
    end else if (adv) begin
      dl_vld <= {dl_vld[DL-2:0], s0_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_info[0] <= s0_info;
      for (int i = 1; i < DL; i++) begin
        dl_info[i] <= dl_info[i-1];
      end
      px <= sa * cb;
      py <= sa * sb;
      pz <= ca;
    end
  end

  always_comb begin
    fin = dl_info[DL-1];
    lo = 18'(segment_count) * 18'(fin.ring - 9'd2);
    hi = 18'(segment_count) * 18'(fin.ring - 9'd1);
    j1 = 18'(fin.seg) + 18'd1;
    jn1 = 18'(fin.segn) + 18'd1;
    bl = 17'(lo + j1);
    br = 17'(lo + jn1);
    tl = 17'(hi + j1);
    tr = 17'(hi + jn1);
    pole = 17'(hi + 18'd1);
    res_c = '0;
    res_c.cls = fin.cls;
    unique case (fin.cls)
      usmc_pkg::CELL_INVALID: begin
        res_c.nfaces = 2'd0;
      end
      usmc_pkg::CELL_NORTH: begin
        res_c.has_vertex = (fin.seg == 8'd0);
        res_c.nfaces = 2'd1;
        res_c.z = usmc_pkg::NORTH_Z;
        res_c.b0 = j1[16:0];
        res_c.c0 = jn1[16:0];
      end
      usmc_pkg::CELL_SOUTH: begin
        res_c.has_vertex = (fin.seg == 8'd0);
        res_c.nfaces = 2'd1;
        res_c.z = usmc_pkg::SOUTH_Z;
        res_c.vid = pole;
        res_c.a0 = br;
        res_c.b0 = bl;
        res_c.c0 = pole;
      end
      usmc_pkg::CELL_BODY: begin
        res_c.has_vertex = 1'b1;
        res_c.nfaces = (fin.ring > 9'd1) ? 2'd2 : 2'd0;
        res_c.x = usmc_pkg::to_coord(px, 62 - usmc_pkg::COORD_FRAC_BITS);
        res_c.y = usmc_pkg::to_coord(py, 62 - usmc_pkg::COORD_FRAC_BITS);
        res_c.z = usmc_pkg::to_coord(66'(pz), 31 - usmc_pkg::COORD_FRAC_BITS);
        res_c.vid = tl;
        res_c.a0 = br;
        res_c.b0 = bl;
        res_c.c0 = tl;
        res_c.a1 = tl;
        res_c.b1 = tr;
        res_c.c1 = br;
      end
      default: begin
        res_c.nfaces = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= dl_vld[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry <= res_c;
    end
  end

endmodule

>>> design/usmc_back.sv
// Back end: queues finished cells and emits their vertex and face results one per cycle while m_tready is high.
module usmc_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  usmc_pkg::cell_result_t entry,
  output logic                   full,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [119:0]           m_tdata,
  output logic [1:0]             m_tuser,
  output logic                   m_tlast
);

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  usmc_pkg::cell_result_t mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0] count;
  logic [1:0] k;

  usmc_pkg::cell_result_t head;
  logic [1:0] total;
  logic last;
  logic ld;
  logic emit;
  logic pop;
  usmc_pkg::kind_t kind;
  logic [15:0] ox;
  logic [15:0] oy;
  logic [15:0] oz;
  logic [16:0] ovid;
  logic [16:0] oa;
  logic [16:0] ob;
  logic [16:0] oc;

  assign full = (count == (QAW+1)'(QDEPTH));

  always_comb begin
    head = mem[rp];
    total = (head.cls == usmc_pkg::CELL_INVALID) ? 2'd1 :
            2'(head.has_vertex) + head.nfaces;
    last = (k == total - 2'd1);
    ld = !m_tvalid || m_tready;
    emit = ld && (count != '0);
    pop = emit && last;
    kind = usmc_pkg::KIND_FACE;
    ox = '0;
    oy = '0;
    oz = '0;
    ovid = '0;
    oa = '0;
    ob = '0;
    oc = '0;
    if (head.cls == usmc_pkg::CELL_INVALID) begin
      kind = usmc_pkg::KIND_INVALID;
    end else if (head.has_vertex && k == 2'd0) begin
      kind = usmc_pkg::KIND_VERTEX;
      ox = head.x;
      oy = head.y;
      oz = head.z;
      ovid = head.vid;
    end else if ((k - 2'(head.has_vertex)) == 2'd0) begin
      oa = head.a0;
      ob = head.b0;
      oc = head.c0;
    end else begin
      oa = head.a1;
      ob = head.b1;
      oc = head.c1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
      k <= 2'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
      if (emit) begin
        k <= last ? 2'd0 : k + 2'd1;
      end
      if (ld) begin
        m_tvalid <= count != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {4'd0, oc, ob, oa, ovid, oz, oy, ox};
      m_tuser <= kind;
      m_tlast <= last;
    end
  end

endmodule

>>> design/uv_sphere_mesh_cell_unit.sv
// Top level of the UV-sphere cell unit: configuration registers, front end and result queue.
// A cell request passes the divider and sine pipelines before it enters the result queue.
// A new request is accepted every cycle while the four-entry queue has room; the result port
// sends one result per cycle while m_tready is high; two-face body cells give three results.
// Synchronous reset clears all valid flags and the queue and sets ring_count to 8 and
// segment_count to 16; no clearing pass follows.
module uv_sphere_mesh_cell_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // ring [8:0], segment [16:9], zero [23:17]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [119:0] m_tdata,   // coord_x, coord_y, coord_z, vertex_id, corner_a..c, zero
  output logic [1:0]   m_tuser,   // kind [1:0]
  output logic         m_tlast
);

  logic [8:0] ring_count;
  logic [8:0] segment_count;
  logic q_push;
  logic q_full;
  usmc_pkg::cell_result_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_count <= usmc_pkg::RING_COUNT_RST;
      segment_count <= usmc_pkg::SEGMENT_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        usmc_pkg::REG_RING_COUNT: ring_count <= cfg_data;
        usmc_pkg::REG_SEGMENT_COUNT: segment_count <= cfg_data;
        default: ;
      endcase
    end
  end

  usmc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .ring_count    (ring_count),
    .segment_count (segment_count),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .full          (q_full),
    .push          (q_push),
    .entry         (q_entry)
  );

  usmc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .entry    (q_entry),
    .full     (q_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

`ifndef ASSERT_OFF
  a_invalid_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == usmc_pkg::KIND_INVALID) |-> (m_tlast && m_tdata == '0))
    else $error("invalid cell result is not a single zero result");

  a_face_no_coord: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == usmc_pkg::KIND_FACE) |-> (m_tdata[64:0] == '0))
    else $error("face result carries vertex data");

  a_vertex_no_corner: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == usmc_pkg::KIND_VERTEX) |-> (m_tdata[119:65] == '0))
    else $error("vertex result carries face corners");
`endif

endmodule

>>> verif/uv_sphere_mesh_cell_unit_tb.sv
// Testbench for the UV-sphere cell unit: directed and random cells checked against a predictor.
module uv_sphere_mesh_cell_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned ONE = 64'd1 << 31;
  localparam longint unsigned HALF_PI = 64'd3373259426;
  localparam longint unsigned QTR = 64'd1 << 30;

  typedef struct {
    usmc_pkg::kind_t kind;
    logic [15:0] x, y, z;
    logic [16:0] vid, a, b, c;
    logic last;
  } mesh_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic cfg_index = 1'b0;
  logic [8:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [23:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [119:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;

  mesh_result_t mesh_expected[$];
  int unsigned rings = 9'd8;
  int unsigned segs = 9'd16;
  int errors = 0;
  int idle_cycles = 0;
  bit tx_free = 0, rx_free = 0, hold_rx = 0;

  uv_sphere_mesh_cell_unit u_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned taylor_sin(longint unsigned x);
    longint unsigned den[5] = '{110, 72, 42, 20, 6};
    longint unsigned x2, t;
    x2 = (x * x) >> 31;
    t = ONE;
    for (int k = 0; k < 5; k++) t = ONE - ((x2 * t) >> 31) / den[k];
    return (x * t) >> 31;
  endfunction

  function automatic longint unsigned taylor_cos(longint unsigned x);
    longint unsigned den[6] = '{132, 90, 56, 30, 12, 2};
    longint unsigned x2, t;
    x2 = (x * x) >> 31;
    t = ONE;
    for (int k = 0; k < 6; k++) t = ONE - ((x2 * t) >> 31) / den[k];
    return t;
  endfunction

  function automatic longint unsigned quadrant_sin(longint unsigned f);
    if (f <= (QTR >> 1)) return taylor_sin((f * HALF_PI) >> 30);
    return taylor_cos(((QTR - f) * HALF_PI) >> 30);
  endfunction

  function automatic longint turn_sin(logic [31:0] p);
    longint unsigned f;
    longint m;
    f = longint'(p[29:0]);
    m = p[30] ? longint'(quadrant_sin(QTR - f)) : longint'(quadrant_sin(f));
    return p[31] ? -m : m;
  endfunction

  function automatic logic [15:0] round_coord(longint v, int sh);
    longint unsigned mag, r;
    mag = (v < 0) ? longint'(-v) : v;
    r = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) return (r > 32768) ? 16'h8000 : 16'(-longint'(r));
    return (r > 32767) ? 16'h7fff : r[15:0];
  endfunction

  function automatic mesh_result_t mk(usmc_pkg::kind_t k, logic [15:0] x, logic [15:0] y,
                                      logic [15:0] z, longint unsigned vid,
                                      longint unsigned a, longint unsigned b,
                                      longint unsigned c);
    mesh_result_t m;
    m.kind = k; m.x = x; m.y = y; m.z = z;
    m.vid = vid[16:0]; m.a = a[16:0]; m.b = b[16:0]; m.c = c[16:0];
    m.last = 1'b0;
    return m;
  endfunction

  function automatic void queue_result(mesh_result_t m);
    mesh_expected = {mesh_expected, m};
  endfunction

  task automatic predict_cell(int unsigned ring, int unsigned j);
    longint unsigned r, s, jn, bl, br, tl, tr, pa64, pb64;
    logic [31:0] pa, pb;
    longint sa, ca, sb, cb;
    ring = ring & 9'h1ff;
    j = j & 8'hff;
    r = rings;
    s = segs;
    if (r < 1 || r > 256 || s < 3 || s > 256 || ring > r + 1 || j >= s) begin
      queue_result(mk(usmc_pkg::KIND_INVALID, 0, 0, 0, 0, 0, 0, 0));
    end else begin
      jn = (j + 1 == s) ? 0 : j + 1;
      if (ring == 0) begin
        if (j == 0) queue_result(mk(usmc_pkg::KIND_VERTEX, 0, 0, 16'd16384, 0, 0, 0, 0));
        queue_result(mk(usmc_pkg::KIND_FACE, 0, 0, 0, 0, 0, j + 1, jn + 1));
      end else if (ring == r + 1) begin
        bl = 1 + (r - 1) * s + j;
        br = 1 + (r - 1) * s + jn;
        if (j == 0) begin
          queue_result(mk(usmc_pkg::KIND_VERTEX, 0, 0, 16'hc000, r * s + 1, 0, 0, 0));
        end
        queue_result(mk(usmc_pkg::KIND_FACE, 0, 0, 0, 0, br, bl, r * s + 1));
      end else begin
        pa64 = (longint'(ring) << 32) / (2 * (r + 1));
        pb64 = (jn << 32) / s;
        pa = pa64[31:0];
        pb = pb64[31:0];
        sa = turn_sin(pa);
        ca = turn_sin(pa + 32'h4000_0000);
        sb = turn_sin(pb);
        cb = turn_sin(pb + 32'h4000_0000);
        queue_result(mk(usmc_pkg::KIND_VERTEX, round_coord(sa * cb, 48),
                        round_coord(sa * sb, 48), round_coord(ca, 17),
                        1 + (ring - 1) * s + j, 0, 0, 0));
        if (ring > 1) begin
          bl = s * (ring - 2) + j + 1;
          br = s * (ring - 2) + jn + 1;
          tl = s * (ring - 1) + j + 1;
          tr = s * (ring - 1) + jn + 1;
          queue_result(mk(usmc_pkg::KIND_FACE, 0, 0, 0, 0, br, bl, tl));
          queue_result(mk(usmc_pkg::KIND_FACE, 0, 0, 0, 0, tl, tr, br));
        end
      end
    end
    mesh_expected[mesh_expected.size() - 1].last = 1'b1;
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int pick_gap(bit free);
    int r;
    if (free) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_cell(int unsigned ring, int unsigned j);
    int gap;
    gap = pick_gap(tx_free);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, j[7:0], ring[8:0]};
    do @(posedge clk); while (!s_tready);
    predict_cell(ring, j);
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (mesh_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(usmc_pkg::reg_index_t idx, int unsigned value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == usmc_pkg::REG_RING_COUNT) rings = value & 9'h1ff;
    else segs = value & 9'h1ff;
  endtask

  task automatic set_shape(int unsigned r, int unsigned s);
    drain();
    write_reg(usmc_pkg::REG_RING_COUNT, r);
    write_reg(usmc_pkg::REG_SEGMENT_COUNT, s);
  endtask

  task automatic send_random_cell();
    int unsigned ring, j;
    if ($urandom_range(0, 99) < 85 && segs >= 1 && rings + 1 <= 511) begin
      ring = $urandom_range(0, rings + 1);
      j = $urandom_range(0, (segs > 256 ? 256 : segs) - 1);
    end else begin
      ring = $urandom_range(0, 511);
      j = $urandom_range(0, 255);
    end
    send_cell(ring, j);
  endtask

  task automatic directed_shape();
    send_cell(0, 0);
    send_cell(0, 1);
    send_cell(0, segs - 1);
    send_cell(1, 0);
    send_cell(2, segs - 1);
    send_cell(rings, segs / 2);
    send_cell(rings + 1, 0);
    send_cell(rings + 1, segs - 1);
    send_cell(rings + 2, 0);
    send_cell(0, segs);
  endtask

  task automatic test_default_shape();
    directed_shape();
    send_cell(511, 255);
  endtask

  task automatic test_extreme_shapes();
    set_shape(1, 3);
    directed_shape();
    set_shape(256, 256);
    send_cell(256, 255);
    send_cell(257, 255);
    send_cell(257, 0);
    send_cell(128, 64);
  endtask

  task automatic test_bad_config();
    set_shape(0, 16);
    send_cell(0, 0);
    set_shape(257, 16);
    send_cell(1, 0);
    set_shape(8, 2);
    send_cell(0, 0);
    set_shape(8, 257);
    send_cell(1, 1);
    set_shape(511, 511);
    send_cell(2, 2);
  endtask

  task automatic test_random_shapes();
    for (int p = 0; p < 4; p++) begin
      set_shape($urandom_range(1, 40), $urandom_range(3, 40));
      tx_free = (p == 1);
      rx_free = (p == 1);
      repeat (18) send_random_cell();
    end
    set_shape(256, 256);
    repeat (20) send_random_cell();
    tx_free = 0;
    rx_free = 0;
  endtask

  task automatic test_backpressure();
    set_shape(12, 9);
    hold_rx = 1'b1;
    tx_free = 1;
    repeat (90) send_cell($urandom_range(2, 12), $urandom_range(0, 8));
    tx_free = 0;
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_rx) begin
      m_tready <= 1'b0;
      repeat (HOLD_CYCLES - 1) @(negedge clk);
      hold_rx = 1'b0;
    end else if (rst) begin
      m_tready <= 1'b0;
    end else begin
      int gap;
      gap = pick_gap(rx_free);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    mesh_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (mesh_expected.size() == 0) begin
        report_mismatch("unexpected result kind", m_tuser, 0);
      end else begin
        want = mesh_expected.pop_front();
        if (m_tuser !== want.kind) report_mismatch("kind", m_tuser, want.kind);
        if (m_tdata[15:0] !== want.x) report_mismatch("coord_x", m_tdata[15:0], want.x);
        if (m_tdata[31:16] !== want.y) report_mismatch("coord_y", m_tdata[31:16], want.y);
        if (m_tdata[47:32] !== want.z) report_mismatch("coord_z", m_tdata[47:32], want.z);
        if (m_tdata[64:48] !== want.vid) report_mismatch("vertex_id", m_tdata[64:48], want.vid);
        if (m_tdata[81:65] !== want.a) report_mismatch("corner_a", m_tdata[81:65], want.a);
        if (m_tdata[98:82] !== want.b) report_mismatch("corner_b", m_tdata[98:82], want.b);
        if (m_tdata[115:99] !== want.c) report_mismatch("corner_c", m_tdata[115:99], want.c);
        if (m_tdata[119:116] !== 4'd0) report_mismatch("padding", m_tdata[119:116], 0);
        if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("uv_sphere_mesh_cell_unit_tb: errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_shape();
    test_extreme_shapes();
    test_bad_config();
    test_random_shapes();
    test_backpressure();
    drain();
    if (mesh_expected.size() != 0) report_mismatch("results left over", mesh_expected.size(), 0);
    if (errors == 0) begin
      $display("uv_sphere_mesh_cell_unit_tb: clean");
    end else begin
      $display("uv_sphere_mesh_cell_unit_tb: errors");
    end
    $finish;
  end
endmodule
